[hdl/spaced_point_placement_filter_assert.svh]
// Assertion macros for the checker file
`ifndef SPACED_POINT_PLACEMENT_FILTER_ASSERT_SVH
`define SPACED_POINT_PLACEMENT_FILTER_ASSERT_SVH
`define SPPF_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error("lbl");
`define SPPF_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error("lbl");
`endif

[hdl/sppf_pkg.sv]
package sppf_pkg;
	localparam int MAX_POINTS = 64;
	localparam int MAX_OBSTACLES = 8;
	localparam int COORD_BITS = 16;
	localparam int PT_BITS = $clog2(MAX_POINTS);
	localparam int OB_BITS = $clog2(MAX_OBSTACLES);
	localparam int CNT_BITS = 7;
	localparam int OBC_BITS = 4;
	localparam int RAD_BITS = 12;
	localparam int LIM_BITS = 2 * (RAD_BITS + 3) + 1;
	localparam int SQ_BITS = 2 * COORD_BITS + 1;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_TEST = 2'd2;

	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_OBSTACLE = 3'd1;
	localparam logic [2:0] ST_CLOSE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_TARGET = 2'd1;
	localparam logic [1:0] REG_OBSTACLES = 2'd2;

	typedef enum logic [1:0] {OP_LOAD, OP_CLEAR, OP_TEST, OP_NOP} op_t;

	typedef struct packed {
		op_t op;
		logic [OB_BITS-1:0] slot;
		logic slot_ok;
		logic [COORD_BITS-1:0] xl, yl, xh, yh;
		logic [COORD_BITS-1:0] cx, cy;
	} job_t;

	typedef enum logic [2:0] {B_IDLE, B_OBST, B_PTRD, B_PTCMP, B_DONE} bstate_t;
endpackage

[hdl/sppf_front.sv]
module sppf_front (
	input logic start,
	input logic [1:0] func,
	input logic [2:0] slot,
	input logic [15:0] x_low,
	input logic [15:0] y_low,
	input logic [15:0] x_high,
	input logic [15:0] y_high,
	input logic [15:0] cand_x,
	input logic [15:0] cand_y,
	input logic q_full,
	output logic q_push,
	output sppf_pkg::job_t q_job
);
	import sppf_pkg::*;
	op_t op;
	always_comb begin
		case (func)
			FUNC_LOAD: op = OP_LOAD;
			FUNC_CLEAR: op = OP_CLEAR;
			FUNC_TEST: op = OP_TEST;
			default: op = OP_NOP;
		endcase
	end
	assign q_push = start && !q_full;
	always_comb begin
		q_job.op = op;
		q_job.slot = slot[OB_BITS-1:0];
		q_job.slot_ok = ({29'd0, slot} < MAX_OBSTACLES);
		q_job.xl = x_low[COORD_BITS-1:0];
		q_job.yl = y_low[COORD_BITS-1:0];
		q_job.xh = x_high[COORD_BITS-1:0];
		q_job.yh = y_high[COORD_BITS-1:0];
		q_job.cx = cand_x[COORD_BITS-1:0];
		q_job.cy = cand_y[COORD_BITS-1:0];
	end
endmodule

[hdl/sppf_queue.sv]
module sppf_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sppf_pkg::job_t din,
	output logic full,
	input logic pop,
	output logic avail,
	output sppf_pkg::job_t dout
);
	import sppf_pkg::*;
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[hdl/sppf_back.sv]
module sppf_back (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input sppf_pkg::job_t job,
	output logic pop,
	input logic [11:0] radius,
	input logic [6:0] target,
	input logic [3:0] obs_cnt,
	output logic done,
	output logic [2:0] status,
	output logic [6:0] placed_count,
	output logic layout_full
);
	import sppf_pkg::*;
	bstate_t st_q, st_d;
	logic [COORD_BITS*4-1:0] obst_q [MAX_OBSTACLES];
	logic [COORD_BITS*2-1:0] pts_q [MAX_POINTS];
	logic [CNT_BITS-1:0] total_q;
	logic [PT_BITS:0] idx_q;
	logic [OB_BITS:0] oidx_q;
	logic [COORD_BITS*2-1:0] rd_s1;
	logic [SQ_BITS-1:0] dx2_s2, dy2_s2;
	logic cmp_v_s1, cmp_v_s2;
	logic [LIM_BITS-1:0] lim2_q;
	logic [RAD_BITS+2:0] lim;
	logic [2:0] res_q;
	logic [CNT_BITS-1:0] eff_tgt;
	logic [OB_BITS:0] eff_obs;
	logic [COORD_BITS-1:0] rxl, ryl, rxh, ryh, px, py, dx, dy;
	logic hit_in, hit_close;
	logic [SQ_BITS:0] dsum;

	assign eff_tgt = (target > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : target;
	assign eff_obs = (obs_cnt > OBC_BITS'(MAX_OBSTACLES)) ? (OB_BITS+1)'(MAX_OBSTACLES)
		: (OB_BITS+1)'(obs_cnt);
	assign lim = {radius, 3'b000};
	assign {rxl, ryl, rxh, ryh} = obst_q[oidx_q[OB_BITS-1:0]];
	assign hit_in = (job.cx > rxl) && (job.cy > ryl) && (job.cx < rxh) && (job.cy < ryh);
	assign {px, py} = rd_s1;
	assign dx = (job.cx > px) ? job.cx - px : px - job.cx;
	assign dy = (job.cy > py) ? job.cy - py : py - job.cy;
	assign dsum = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign hit_close = cmp_v_s2 && (dsum <= (SQ_BITS+1)'(lim2_q));

	always_ff @(posedge clk) begin
		lim2_q <= LIM_BITS'(lim * lim);
		rd_s1 <= pts_q[idx_q[PT_BITS-1:0]];
		dx2_s2 <= SQ_BITS'(dx * dx);
		dy2_s2 <= SQ_BITS'(dy * dy);
		if (st_q == B_IDLE && avail && job.op == OP_LOAD && job.slot_ok)
			obst_q[job.slot] <= {job.xl, job.yl, job.xh, job.yh};
		if (st_q == B_PTRD && idx_q == (PT_BITS+1)'(total_q) && !hit_close && !cmp_v_s1)
			pts_q[total_q[PT_BITS-1:0]] <= {job.cx, job.cy};
	end

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		case (st_q)
			B_IDLE: if (avail) begin
				if (job.op == OP_TEST && total_q < eff_tgt) st_d = B_OBST;
				else st_d = B_DONE;
			end
			B_OBST: begin
				if (hit_in && oidx_q < eff_obs) st_d = B_DONE;
				else if (oidx_q >= eff_obs) st_d = B_PTRD;
			end
			B_PTRD: if (hit_close || (idx_q == (PT_BITS+1)'(total_q) && !cmp_v_s1 && !cmp_v_s2))
				st_d = B_DONE;
			B_DONE: begin
				pop = 1'b1;
				st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			total_q <= '0;
			idx_q <= '0;
			oidx_q <= '0;
			cmp_v_s1 <= 1'b0;
			cmp_v_s2 <= 1'b0;
			res_q <= ST_DONE;
			done <= 1'b0;
			status <= ST_DONE;
			placed_count <= '0;
			layout_full <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == B_DONE);
			cmp_v_s2 <= cmp_v_s1;
			// issue one stored point per cycle until the count is reached
			cmp_v_s1 <= (st_q == B_PTRD) && !hit_close && (idx_q != (PT_BITS+1)'(total_q));
			case (st_q)
				B_IDLE: begin
					idx_q <= '0;
					oidx_q <= '0;
					if (avail) begin
						if (job.op == OP_CLEAR) begin
							total_q <= '0;
							res_q <= ST_DONE;
						end else if (job.op == OP_TEST) res_q <= ST_FULL;
						else res_q <= ST_DONE;
					end
				end
				B_OBST: begin
					if (hit_in && oidx_q < eff_obs) res_q <= ST_OBSTACLE;
					else if (oidx_q < eff_obs) oidx_q <= oidx_q + 1'b1;
				end
				B_PTRD: begin
					if (hit_close) res_q <= ST_CLOSE;
					else if (idx_q != (PT_BITS+1)'(total_q)) idx_q <= idx_q + 1'b1;
					else if (!cmp_v_s1 && !cmp_v_s2) begin
						res_q <= ST_ACCEPT;
						total_q <= total_q + 1'b1;
					end
				end
				B_DONE: begin
					status <= res_q;
					placed_count <= total_q;
					layout_full <= (total_q >= eff_tgt);
				end
				default: ;
			endcase
		end
	end
endmodule

[hdl/spaced_point_placement_filter.sv]
// For load, clear, unused code and full, the back end goes from idle to its done state, and done is registered from it.
// A candidate test first scans the n obstacles in use, one per cycle, then compares each stored point
// through its registered read and square stages; a hit ends its scan early.
// Throughput: one word at a time in the back end; a two-entry queue takes words while busy is low.
// The result strobe (done) lasts one cycle; the receiver cannot stall.
// Reset clears counts and state and sets the target register to 64; obstacle and point stores are not cleared.
module spaced_point_placement_filter (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] func,
	input logic [2:0] slot,
	input logic [15:0] x_low,
	input logic [15:0] y_low,
	input logic [15:0] x_high,
	input logic [15:0] y_high,
	input logic [15:0] cand_x,
	input logic [15:0] cand_y,
	output logic done,
	output logic [2:0] status,
	output logic [6:0] placed_count,
	output logic layout_full,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);
	import sppf_pkg::*;
	logic q_full, q_push, q_pop, q_avail;
	job_t q_in, q_out;
	logic [11:0] radius_q;
	logic [6:0] target_q;
	logic [3:0] obs_q;

	assign busy = q_full;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			target_q <= 7'd64;
			obs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_TARGET: target_q <= cfg_data[6:0];
				REG_OBSTACLES: obs_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	sppf_front u_front (.start, .func, .slot, .x_low, .y_low, .x_high,
		.y_high, .cand_x, .cand_y, .q_full, .q_push, .q_job(q_in));
	sppf_queue u_queue (.clk, .arst_n, .push(q_push), .din(q_in), .full(q_full),
		.pop(q_pop), .avail(q_avail), .dout(q_out));
	sppf_back u_back (.clk, .arst_n, .avail(q_avail), .job(q_out), .pop(q_pop),
		.radius(radius_q), .target(target_q), .obs_cnt(obs_q), .done, .status,
		.placed_count, .layout_full);
endmodule

[hdl/sppf_checker.sv]
`include "spaced_point_placement_filter_assert.svh"
module sppf_checker (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic [2:0] status,
	input logic [6:0] placed_count,
	input logic layout_full
);
	import sppf_pkg::*;
	`SPPF_ASSERT_IMPL(a_status_range, done, status <= ST_DONE)
	`SPPF_ASSERT_IMPL(a_count_range, done, placed_count <= 7'd64)
	`SPPF_ASSERT_NEXT(a_done_pulse, done, !done)
	`SPPF_ASSERT_IMPL(a_full_status, done && status == ST_FULL, layout_full)
endmodule
bind spaced_point_placement_filter sppf_checker u_chk (.clk, .arst_n, .done, .status,
	.placed_count, .layout_full);

[verif/spaced_point_placement_filter_tb.sv]
module spaced_point_placement_filter_tb;
	import sppf_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic [2:0] status;
		logic [6:0] placed_count;
		logic layout_full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = '0;
	logic [2:0] slot = '0;
	logic [15:0] x_low = '0, y_low = '0, x_high = '0, y_high = '0;
	logic [15:0] cand_x = '0, cand_y = '0;
	logic done;
	logic [2:0] status;
	logic [6:0] placed_count;
	logic layout_full;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	// layout mirror
	logic [15:0] rect_xl[MAX_OBSTACLES], rect_yl[MAX_OBSTACLES];
	logic [15:0] rect_xh[MAX_OBSTACLES], rect_yh[MAX_OBSTACLES];
	logic [15:0] spot_x[MAX_POINTS], spot_y[MAX_POINTS];
	int unsigned spots_held;
	logic [11:0] radius_reg;
	logic [6:0] target_reg;
	logic [3:0] obst_reg;

	verdict_t pending_verdicts[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	spaced_point_placement_filter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func), .slot(slot),
		.x_low(x_low), .y_low(y_low), .x_high(x_high), .y_high(y_high),
		.cand_x(cand_x), .cand_y(cand_y), .done(done), .status(status),
		.placed_count(placed_count), .layout_full(layout_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic logic [2:0] rnd3();
		return 3'($urandom);
	endfunction

	function automatic int unsigned goal();
		return (target_reg > MAX_POINTS) ? MAX_POINTS : target_reg;
	endfunction

	function automatic bit blocked(logic [15:0] px, logic [15:0] py);
		int unsigned n;
		n = (obst_reg > MAX_OBSTACLES) ? MAX_OBSTACLES : obst_reg;
		for (int i = 0; i < n; i++)
			if (px > rect_xl[i] && py > rect_yl[i] && px < rect_xh[i] && py < rect_yh[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit crowded(logic [15:0] px, logic [15:0] py);
		longint unsigned lim, dx, dy;
		lim = longint'(radius_reg) * 8;
		for (int i = 0; i < spots_held; i++) begin
			dx = (px > spot_x[i]) ? px - spot_x[i] : spot_x[i] - px;
			dy = (py > spot_y[i]) ? py - spot_y[i] : spot_y[i] - py;
			if (dx * dx + dy * dy <= lim * lim)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t place_word(logic [1:0] f, logic [2:0] s, logic [15:0] xl,
			logic [15:0] yl, logic [15:0] xh, logic [15:0] yh, logic [15:0] cx, logic [15:0] cy);
		verdict_t v;
		v.status = ST_DONE;
		case (op_t'(f))
			OP_LOAD: begin
				rect_xl[s] = xl; rect_yl[s] = yl; rect_xh[s] = xh; rect_yh[s] = yh;
			end
			OP_CLEAR: spots_held = 0;
			OP_TEST: begin
				if (spots_held >= goal())
					v.status = ST_FULL;
				else if (blocked(cx, cy))
					v.status = ST_OBSTACLE;
				else if (crowded(cx, cy))
					v.status = ST_CLOSE;
				else begin
					spot_x[spots_held] = cx;
					spot_y[spots_held] = cy;
					spots_held++;
					v.status = ST_ACCEPT;
				end
			end
			default: ;
		endcase
		v.placed_count = spots_held[6:0];
		v.layout_full = (spots_held >= goal());
		return v;
	endfunction

	// call at a rising edge; leaves start high unless a gap follows
	task automatic send_word(logic [1:0] f, logic [2:0] s, logic [15:0] xl, logic [15:0] yl,
			logic [15:0] xh, logic [15:0] yh, logic [15:0] cx, logic [15:0] cy);
		verdict_t v;
		start <= 1'b1;
		func <= f; slot <= s;
		x_low <= xl; y_low <= yl; x_high <= xh; y_high <= yh;
		cand_x <= cx; cand_y <= cy;
		do @(posedge clk); while (busy);
		v = place_word(f, s, xl, yl, xh, yh, cx, cy);
		pending_verdicts = {pending_verdicts, v};
		if (!steady && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic probe(logic [15:0] cx, logic [15:0] cy);
		send_word(OP_TEST, rnd3(), rnd16(), rnd16(), rnd16(), rnd16(), cx, cy);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RADIUS: radius_reg = val;
			REG_TARGET: target_reg = val[6:0];
			REG_OBSTACLES: obst_reg = val[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_directed();
		// fill every slot before any is put in use
		for (int i = 0; i < MAX_OBSTACLES; i++)
			send_word(OP_LOAD, 3'(i), 16'(100 * i), 16'(100 * i), 16'(100 * i + 50),
				16'(100 * i + 50), 16'd0, 16'd0);
		send_word(OP_LOAD, 3'd7, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0);  // inverted bounds
		send_word(OP_LOAD, 3'd6, 16'd0, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0);
		send_word(OP_NOP, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		probe(16'd0, 16'd0);
		probe(16'd0, 16'd0);              // zero radius: coincident is too close
		probe(16'hffff, 16'hffff);
		write_reg(REG_RADIUS, 12'hfff);
		probe(16'h8000, 16'h8000);
		send_word(OP_CLEAR, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_reg(REG_OBSTACLES, 12'd8);
		probe(16'd0, 16'd0);              // on the edge of the full rectangle
		probe(16'd10, 16'd10);
		send_word(OP_LOAD, 3'd6, 16'd1000, 16'd1000, 16'd2000, 16'd2000, 16'd0, 16'd0);
		probe(16'd1000, 16'd1500);
		probe(16'd1500, 16'd1500);
		write_reg(REG_OBSTACLES, 12'd15);
		write_reg(REG_RADIUS, 12'd1);
		probe(16'd3000, 16'd3000);
		probe(16'd3008, 16'd3000);        // exactly at the limit
		probe(16'd3009, 16'd3000);
		probe(16'd3010, 16'd3000);
		write_reg(REG_TARGET, 12'd0);
		probe(16'd40000, 16'd40000);
		write_reg(REG_TARGET, 12'd127);
		probe(16'd50000, 16'd50000);
		write_reg(REG_OBSTACLES, 12'd0);
		write_reg(REG_TARGET, 12'd2);
		probe(16'd60000, 16'd60000);
	endtask

	task automatic random_word(int unsigned span);
		logic [15:0] a, b;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			a = rnd16(); b = rnd16();
			if ($urandom_range(0, 1))
				send_word(OP_LOAD, rnd3(), a, b, 16'(a + $urandom_range(0, 3000)),
					16'(b + $urandom_range(0, 3000)), rnd16(), rnd16());
			else
				send_word(OP_LOAD, rnd3(), a, b, rnd16(), rnd16(), rnd16(), rnd16());
		end else if (pick < 9)
			send_word(OP_CLEAR, rnd3(), rnd16(), rnd16(), rnd16(), rnd16(),
				rnd16(), rnd16());
		else if (pick < 11)
			send_word(OP_NOP, rnd3(), rnd16(), rnd16(), rnd16(), rnd16(),
				rnd16(), rnd16());
		else if (span == 0)
			probe(rnd16(), rnd16());
		else
			probe(16'($urandom_range(0, span)), 16'($urandom_range(0, span)));
	endtask

	task automatic test_random(int unsigned phases, int unsigned per_phase);
		int unsigned span;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_RADIUS, 12'hfff);
				1: write_reg(REG_RADIUS, 12'd0);
				default: write_reg(REG_RADIUS, 12'($urandom_range(0, 400)));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(REG_TARGET, 12'd0);
				1: write_reg(REG_TARGET, 12'd127);
				2: write_reg(REG_TARGET, 12'd64);
				default: write_reg(REG_TARGET, 12'($urandom));
			endcase
			write_reg(REG_OBSTACLES, 12'($urandom));
			span = $urandom_range(0, 1) ? 0 : $urandom_range(2000, 20000);
			for (int i = 0; i < per_phase; i++)
				random_word(span);
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with nothing pending");
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					errors++;
				end
				if (placed_count !== want.placed_count) begin
					$error("placed_count expected %0d actual %0d", want.placed_count,
						placed_count);
					errors++;
				end
				if (layout_full !== want.layout_full) begin
					$error("layout_full expected %0d actual %0d", want.layout_full,
						layout_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[spaced_point_placement_filter] ERROR");
			$finish;
		end
	end

	initial begin
		spots_held = 0;
		radius_reg = '0;
		target_reg = 7'd64;
		obst_reg = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(12, 75);
		steady = 1'b1;
		test_random(2, 60);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("[spaced_point_placement_filter] OK");
		else
			$display("[spaced_point_placement_filter] ERROR");
		$finish;
	end
endmodule
